/* rtl/oaht_pkg.sv */
package oaht_pkg;

   localparam int KeyWidth   = 31;
   localparam int ValueWidth = 32;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  operation;
      logic [KeyWidth-1:0]     lookup_key;
      logic [ValueWidth-1:0]   store_value;
   } req_type;

   typedef struct packed {
      logic                    key_found;
      logic [ValueWidth-1:0]   read_value;
      logic                    table_full;
   } rsp_type;

   typedef struct packed {
      logic                    valid;
      logic [KeyWidth-1:0]     key;
      logic [ValueWidth-1:0]   value;
   } slot_type;

   typedef struct packed {
      logic                    we;
      slot_type                wdata;
   } slot_wr_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } state_type;

endpackage

/* rtl/open_addressing_hash_table_unit.sv */
// channel   dir   handshake              payload
// req       in    req_valid / req_stall  req_data  (req_type)
// rsp       out   rsp_valid / rsp_stall  rsp_data  (rsp_type)
//
// A request takes k = 1..2**AddrWidth probes, one slot RAM read per probe.
// After reset a clearing pass empties all 2**AddrWidth slots of the slot RAM; req_stall is high.
// The response register lets the next request start while a response is stalled.
module open_addressing_hash_table_unit
   import oaht_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int AddrWidth = $clog2(CAPACITY);

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff;
   logic                    rsp_free;
   logic                    done;
   rsp_type                 result;
   logic [AddrWidth-1:0]    rd_addr;
   logic [AddrWidth-1:0]    wr_addr;
   slot_type                rd_data;
   slot_wr_type             wr;

   oaht_probe_seq #(
      .AddrWidth (AddrWidth)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .done      (done),
      .rsp_free  (rsp_free),
      .result    (result),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_addr   (wr_addr),
      .wr        (wr)
   );

   oaht_slot_ram #(
      .AddrWidth (AddrWidth)
   ) u_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (wr_addr),
      .wr      (wr)
   );

   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = done ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done && rsp_free) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/oaht_slot_ram.sv */
module oaht_slot_ram
   import oaht_pkg::*;
#(
   parameter int AddrWidth = 10
) (
   input  logic                  clock,
   input  logic [AddrWidth-1:0]  rd_addr,
   output slot_type              rd_data,
   input  logic [AddrWidth-1:0]  wr_addr,
   input  slot_wr_type           wr
);

   slot_type mem [2**AddrWidth];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr_addr] <= wr.wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/oaht_probe_seq.sv */
module oaht_probe_seq
   import oaht_pkg::*;
#(
   parameter int AddrWidth = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  done,
   input  logic                  rsp_free,
   output rsp_type               result,
   output logic [AddrWidth-1:0]  rd_addr,
   input  slot_type              rd_data,
   output logic [AddrWidth-1:0]  wr_addr,
   output slot_wr_type           wr
);

   state_type               state_ff, state_in;
   logic [AddrWidth-1:0]    pos_ff, pos_in;
   logic [AddrWidth-1:0]    cnt_ff, cnt_in;
   req_type                 req_ff;
   rsp_type                 res_ff, res_in;
   logic                    accept;
   logic                    stop;
   logic                    exhausted;
   logic [AddrWidth-1:0]    addend;
   logic [AddrWidth-1:0]    pos_sum;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign stop      = !rd_data.valid || (rd_data.key == req_ff.lookup_key);
   assign exhausted = (cnt_ff == '1);

   // shared address adder: clear sweep steps by one, probing by probe index + 1
   assign addend  = (state_ff == ST_CLEAR) ? AddrWidth'(1) : cnt_ff + AddrWidth'(1);
   assign pos_sum = pos_ff + addend;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (pos_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (stop || exhausted) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      wr     = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            pos_in   = pos_sum;
            wr.we    = 1'b1;
         end
         ST_IDLE: begin
            pos_in = req_data.lookup_key[AddrWidth-1:0];
            cnt_in = '0;
         end
         ST_PROBE: begin
            if (stop) begin
               res_in.key_found  = rd_data.valid;
               res_in.read_value = (req_ff.operation == OP_GET && rd_data.valid) ?
                                   rd_data.value : '0;
               res_in.table_full = 1'b0;
               if (req_ff.operation == OP_PUT) begin
                  wr.we          = 1'b1;
                  wr.wdata.valid = 1'b1;
                  wr.wdata.key   = req_ff.lookup_key;
                  wr.wdata.value = req_ff.store_value;
               end
            end else if (exhausted) begin
               res_in.key_found  = 1'b0;
               res_in.read_value = '0;
               res_in.table_full = (req_ff.operation == OP_PUT);
            end else begin
               pos_in = pos_sum;
               cnt_in = cnt_ff + AddrWidth'(1);
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      res_ff <= res_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign done      = (state_ff == ST_DONE);
   assign result    = res_ff;
   assign rd_addr   = pos_in;
   assign wr_addr   = pos_ff;

endmodule
